[hw/rtl/dmb_pkg.sv]
// ----------------------------------------------------------------------------
// dmb_pkg
// shared widths, codes and defaults of the density matrix builder
// ----------------------------------------------------------------------------
package dmb_pkg;

	localparam int MAX_BASIS_DEF    = 64;
	localparam int MAX_ORBITALS_DEF = 64;

	// fixed field widths
	localparam int IDX_W    = 6;
	localparam int COEF_W   = 24;
	localparam int CNT_W    = 7;
	localparam int MODE_W   = 2;
	localparam int DENS_W   = 32;
	localparam int PACKED_W = 12;
	localparam int FRAC_W   = 20;

	// input kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// open shell modes (code 3 behaves as closed only)
	localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUMMED = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TWO    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_CLOSED_COUNT = 2'd0;
	localparam logic [1:0] REG_OPEN_COUNT   = 2'd1;
	localparam logic [1:0] REG_OPEN_MODE    = 2'd2;

	// per-column control travelling with the memory read
	typedef struct packed {
		logic clear;
		logic valid;
		logic to_closed;
		logic to_open;
		logic to_two;
	} mac_ctl_t;

endpackage

[hw/rtl/dmb_coef_mem.sv]
// ----------------------------------------------------------------------------
// dmb_coef_mem
// coefficient store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module dmb_coef_mem
	import dmb_pkg::*;
#(
	parameter int DEPTH = MAX_BASIS_DEF * MAX_ORBITALS_DEF,
	parameter int AW    = $clog2(MAX_BASIS_DEF * MAX_ORBITALS_DEF)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [COEF_W-1:0] wdata,
	input  logic                     ren,
	input  logic [AW-1:0]            raddr_a,
	input  logic [AW-1:0]            raddr_b,
	output logic signed [COEF_W-1:0] rdata_a,
	output logic signed [COEF_W-1:0] rdata_b
);

	logic signed [COEF_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[hw/rtl/dmb_mac.sv]
// ----------------------------------------------------------------------------
// dmb_mac
// product stage, three accumulators and Q11.20 rounding with saturation
// ----------------------------------------------------------------------------
module dmb_mac
	import dmb_pkg::*;
#(
	parameter int MAX_ORBITALS = MAX_ORBITALS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 ctl_s1,
	input  logic signed [COEF_W-1:0] coef_a_s1,
	input  logic signed [COEF_W-1:0] coef_b_s1,
	output logic                     busy,
	output logic [DENS_W-1:0]        closed_out,
	output logic [DENS_W-1:0]        open_out,
	output logic [DENS_W-1:0]        two_out
);

	localparam int PROD_W  = 2 * COEF_W;
	localparam int ACC_RAW = PROD_W + $clog2(MAX_ORBITALS) + 1;
	localparam int ACC_W   = (ACC_RAW > 53) ? ACC_RAW : 53;
	localparam int Q_W     = ACC_W + 1 - FRAC_W;

	mac_ctl_t                  ctl_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   closed_acc_q;
	logic signed [ACC_W-1:0]   open_acc_q;
	logic signed [ACC_W-1:0]   two_acc_q;
	logic signed [ACC_W-1:0]   prod_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef_a_s1 * coef_b_s1;
	end

	assign prod_x = ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (ctl_s2.clear) begin
			closed_acc_q <= '0;
			open_acc_q   <= '0;
			two_acc_q    <= '0;
		end else if (ctl_s2.valid) begin
			if (ctl_s2.to_closed) begin
				closed_acc_q <= closed_acc_q + prod_x;
			end
			if (ctl_s2.to_open) begin
				open_acc_q <= open_acc_q + prod_x;
			end
			if (ctl_s2.to_two) begin
				two_acc_q <= two_acc_q + prod_x;
			end
		end
	end

	assign busy = ctl_s1.valid | ctl_s2.valid | ctl_s1.clear | ctl_s2.clear;

	// round half up, floor shift, clamp to 32 bits
	function automatic logic [DENS_W-1:0] to_q11_20(input logic signed [ACC_W-1:0] s);
		logic signed [ACC_W:0] t;
		logic signed [Q_W-1:0] q;
		logic                  fits;
		t    = ACC_W'(s) + (ACC_W+1)'(1 << (FRAC_W - 1));
		t    = $signed({s[ACC_W-1], s}) + $signed((ACC_W+1)'(1 << (FRAC_W - 1)));
		q    = t[ACC_W:FRAC_W];
		fits = (&q[Q_W-1:DENS_W-1]) | ~(|q[Q_W-1:DENS_W-1]);
		if (fits) begin
			to_q11_20 = q[DENS_W-1:0];
		end else if (q[Q_W-1]) begin
			to_q11_20 = {1'b1, {(DENS_W-1){1'b0}}};
		end else begin
			to_q11_20 = {1'b0, {(DENS_W-1){1'b1}}};
		end
	endfunction

	assign closed_out = to_q11_20(closed_acc_q);
	assign open_out   = to_q11_20(open_acc_q);
	assign two_out    = to_q11_20(two_acc_q);

endmodule

[hw/rtl/density_matrix_builder_unit.sv]
// ----------------------------------------------------------------------------
// density_matrix_builder_unit
// closed and open shell density entries from a stored coefficient matrix
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser = kind, tdata = row, col, coefficient
// m_*       out  m_tvalid/m_tready  tdata = closed, open, open two, packed index
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// a load transaction writes the store directly
// a query reads the store once per orbital column below last_col, then runs
//   product and accumulate stages and combinational rounding; last_col is the
//   end of the furthest column range of the current mode, clamped to the orbital count
// reset clears control state only; the store holds garbage until loaded
// a finished result waits in the output register while loads keep flowing;
//   a second query computes and then holds until the output register frees
//
module density_matrix_builder_unit
	import dmb_pkg::*;
#(
	parameter int MAX_BASIS    = MAX_BASIS_DEF,
	parameter int MAX_ORBITALS = MAX_ORBITALS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// slave stream
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,   // row_index[5:0], col_index[11:6], coefficient[35:12]
	input  logic          s_tuser,   // kind[0]
	// master stream
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,   // closed[31:0], open[63:32], open_two[95:64],
	                                 // packed_index[107:96]
	// configuration
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [6:0]    cfg_data
);

	localparam int DEPTH = MAX_BASIS * MAX_ORBITALS;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(MAX_ORBITALS + 1);
	localparam int SW    = (KW > 9) ? KW : 9;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	// configuration registers
	logic [CNT_W-1:0]  closed_count_q;
	logic [CNT_W-1:0]  open_count_q;
	logic [MODE_W-1:0] open_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_count_q <= '0;
			open_count_q   <= '0;
			open_mode_q    <= MODE_CLOSED;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLOSED_COUNT: closed_count_q <= cfg_data;
				REG_OPEN_COUNT:   open_count_q   <= cfg_data;
				REG_OPEN_MODE:    open_mode_q    <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// input unpacking
	logic                     in_kind;
	logic [IDX_W-1:0]         in_row;
	logic [IDX_W-1:0]         in_col;
	logic signed [COEF_W-1:0] in_coef;
	logic                     s_accept;

	assign in_kind  = s_tuser;
	assign in_row   = s_tdata[5:0];
	assign in_col   = s_tdata[11:6];
	assign in_coef  = s_tdata[35:12];
	assign s_accept = s_tvalid & s_tready;

	logic [1:0] state_q;
	assign s_tready = (state_q == ST_IDLE);

	// query setup: order the pair, base addresses, range end
	logic [IDX_W-1:0] hi_row, lo_row;
	logic [SW-1:0]    cc_x, oc_x, end_x;
	logic [KW-1:0]    last_d;

	assign hi_row = (in_row > in_col) ? in_row : in_col;
	assign lo_row = (in_row > in_col) ? in_col : in_row;
	assign cc_x   = SW'(closed_count_q);
	assign oc_x   = SW'(open_count_q);

	always_comb begin
		case (open_mode_q)
			MODE_SUMMED: end_x = cc_x + oc_x;
			MODE_TWO:    end_x = cc_x + SW'(2);
			default:     end_x = cc_x;
		endcase
		if (32'(end_x) > MAX_ORBITALS) begin
			last_d = KW'(MAX_ORBITALS);
		end else begin
			last_d = KW'(end_x);
		end
	end

	logic [AW-1:0]       hi_base_q, lo_base_q;
	logic [KW-1:0]       k_q, last_q;
	logic                row_ok_q;
	logic [PACKED_W-1:0] packed_q;
	logic [PACKED_W-1:0] packed_d;

	// lower-triangle position, small constant-width product
	assign packed_d = PACKED_W'((PACKED_W'(hi_row) * (PACKED_W'(hi_row) + PACKED_W'(1))) >> 1)
		+ PACKED_W'(lo_row);

	// column issue and per-column routing
	logic          issue;
	logic [SW-1:0] k_x;
	mac_ctl_t      ctl_d, ctl_s1;

	assign issue = (state_q == ST_RUN) && (k_q != last_q);
	assign k_x   = SW'(k_q);

	always_comb begin
		ctl_d           = '0;
		ctl_d.clear     = s_accept && (in_kind == KIND_QUERY);
		ctl_d.valid     = issue;
		ctl_d.to_closed = row_ok_q && (k_x < cc_x);
		case (open_mode_q)
			MODE_SUMMED: ctl_d.to_open = row_ok_q && (k_x >= cc_x) && (k_x < cc_x + oc_x);
			MODE_TWO: begin
				ctl_d.to_open = row_ok_q && (k_x == cc_x);
				ctl_d.to_two  = row_ok_q && (k_x == cc_x + SW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_d;
		end
	end

	// store access
	logic                     mem_we;
	logic [AW-1:0]            waddr;
	logic signed [COEF_W-1:0] coef_a, coef_b;

	assign mem_we = s_accept && (in_kind == KIND_LOAD)
		&& (32'(in_row) < MAX_BASIS) && (32'(in_col) < MAX_ORBITALS);
	assign waddr  = AW'(32'(in_row) * MAX_ORBITALS) + AW'(in_col);

	dmb_coef_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (waddr),
		.wdata  (in_coef),
		.ren    (issue),
		.raddr_a(hi_base_q + AW'(k_q)),
		.raddr_b(lo_base_q + AW'(k_q)),
		.rdata_a(coef_a),
		.rdata_b(coef_b)
	);

	logic                  mac_busy;
	logic [DENS_W-1:0]     closed_res, open_res, two_res;

	dmb_mac #(
		.MAX_ORBITALS(MAX_ORBITALS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.coef_a_s1 (coef_a),
		.coef_b_s1 (coef_b),
		.busy      (mac_busy),
		.closed_out(closed_res),
		.open_out  (open_res),
		.two_out   (two_res)
	);

	// query payload registers
	always_ff @(posedge clk) begin
		if (s_accept && (in_kind == KIND_QUERY)) begin
			hi_base_q <= AW'(32'(hi_row) * MAX_ORBITALS);
			lo_base_q <= AW'(32'(lo_row) * MAX_ORBITALS);
			row_ok_q  <= (32'(hi_row) < MAX_BASIS);
			last_q    <= last_d;
			packed_q  <= packed_d;
		end
	end

	// sequencer
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept && (in_kind == KIND_QUERY)) begin
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						k_q <= k_q + KW'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for the last product to land in the accumulators
					if (!mac_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	logic m_tvalid_q;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {4'd0, packed_q, two_res, open_res, closed_res};
		end
	end

endmodule

[sim/tb_density_matrix_builder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_density_matrix_builder_unit
// self-checking bench: loads coefficient rows, queries density entries under
// a sweep of closed/open settings and compares every result with a predictor
// ----------------------------------------------------------------------------
module tb_density_matrix_builder_unit;
	import dmb_pkg::*;

	localparam int NROWS = MAX_BASIS_DEF;
	localparam int NCOLS = MAX_ORBITALS_DEF;

	// register index with no register behind it, and the undefined mode code
	localparam logic [1:0]        REG_SPARE  = 2'd3;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam logic [COEF_W-1:0] COEF_MIN = 24'h800000;
	localparam logic [COEF_W-1:0] COEF_MAX = 24'h7fffff;

	localparam int PHASE_ITEMS    = 135;
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	// one density result as the block reports it
	typedef struct {
		logic [DENS_W-1:0]   closed_d;
		logic [DENS_W-1:0]   open_d;
		logic [DENS_W-1:0]   open_two_d;
		logic [PACKED_W-1:0] tri_index;
	} density_entry_t;

	// predictor plus queue of outstanding density results
	class density_scoreboard;
		logic signed [COEF_W-1:0] coef_mem [NROWS][NCOLS];
		int                       closed_cols;
		int                       open_cols;
		logic [MODE_W-1:0]        open_sel;
		density_entry_t           due_q [$];
		int                       errors;

		function new();
			foreach (coef_mem[r, c]) coef_mem[r][c] = '0;
			closed_cols = 0;
			open_cols   = 0;
			open_sel    = MODE_CLOSED;
			errors      = 0;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void write_reg(logic [1:0] idx, logic [CNT_W-1:0] val);
			case (idx)
				REG_CLOSED_COUNT: closed_cols = int'(val);
				REG_OPEN_COUNT:   open_cols   = int'(val);
				REG_OPEN_MODE:    open_sel    = val[MODE_W-1:0];
				default: ;        // unused index, no effect
			endcase
		endfunction

		// exact q13.40 sum over columns [col_lo, col_end), clamped to the store
		function longint column_sum(int ra, int rb, int col_lo, int col_end);
			longint acc = 0;
			if (col_end > NCOLS)
				col_end = NCOLS;
			for (int k = col_lo; k < col_end; k++)
				acc += longint'(coef_mem[ra][k]) * longint'(coef_mem[rb][k]);
			return acc;
		endfunction

		// round half up to q11.20, then saturate to 32 bits
		function logic [DENS_W-1:0] round_sat(longint s);
			longint q;
			q = (s + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
			if (q > 64'sd2147483647)
				q = 64'sd2147483647;
			else if (q < -64'sd2147483648)
				q = -64'sd2147483648;
			return q[DENS_W-1:0];
		endfunction

		function density_entry_t predict_entry(int a, int b);
			density_entry_t e;
			int             hi_r;
			int             lo_r;
			hi_r = (a > b) ? a : b;
			lo_r = (a > b) ? b : a;
			e.closed_d   = round_sat(column_sum(hi_r, lo_r, 0, closed_cols));
			e.open_d     = '0;
			e.open_two_d = '0;
			case (open_sel)
				MODE_SUMMED: begin
					e.open_d = round_sat(column_sum(hi_r, lo_r, closed_cols,
						closed_cols + open_cols));
				end
				MODE_TWO: begin
					e.open_d     = round_sat(column_sum(hi_r, lo_r, closed_cols,
						closed_cols + 1));
					e.open_two_d = round_sat(column_sum(hi_r, lo_r, closed_cols + 1,
						closed_cols + 2));
				end
				default: ;        // closed only, the undefined code included
			endcase
			e.tri_index = PACKED_W'(hi_r * (hi_r + 1) / 2 + lo_r);
			return e;
		endfunction

		function void note_input(logic kind, logic [IDX_W-1:0] row,
			logic [IDX_W-1:0] col, logic [COEF_W-1:0] coef);
			if (kind == KIND_LOAD)
				coef_mem[row][col] = coef;
			else
				due_q.push_back(predict_entry(int'(row), int'(col)));
		endfunction

		function void check_result(logic [111:0] word);
			density_entry_t    want;
			logic [DENS_W-1:0] w [4];
			logic [DENS_W-1:0] g [4];
			string             label [4];
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t unexpected density result: expected none, got %h",
					$time, word);
				return;
			end
			want  = due_q.pop_front();
			label = '{"closed_density", "open_density", "open_density_two",
				"packed_index"};
			w = '{want.closed_d, want.open_d, want.open_two_d, DENS_W'(want.tri_index)};
			g = '{word[31:0], word[63:32], word[95:64], DENS_W'(word[107:96])};
			for (int f = 0; f < 4; f++) begin
				if (g[f] !== w[f]) begin
					errors++;
					$display("%0t %s mismatch: expected %h, got %h",
						$time, label[f], w[f], g[f]);
				end
			end
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [39:0]    s_tdata;    // row_index[5:0], col_index[11:6], coefficient[35:12]
	logic           s_tuser;    // kind[0]
	logic           m_tvalid;
	logic           m_tready;
	logic [111:0]   m_tdata;    // closed[31:0], open[63:32], open_two[95:64],
	                            // packed_index[107:96]
	logic           cfg_we;
	logic [1:0]     cfg_index;
	logic [6:0]     cfg_data;

	density_scoreboard sb = new();

	// stimulus side bookkeeping: which store entries hold a written value
	bit                loaded [NROWS][NCOLS];
	int                fill_rows [8];
	int                cur_closed;
	int                cur_open;
	logic [MODE_W-1:0] cur_mode;
	bit                gaps_on;
	bit                hold_off_req;
	int                quiet_cycles;

	density_matrix_builder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sample every handshake at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tuser, s_tdata[5:0], s_tdata[11:6], s_tdata[35:12]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			// watchdog: any transaction or register write counts as progress
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result sink: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int stall;
		bit holding;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			holding = hold_off_req;
			if (holding) begin
				stall        = HOLD_CYCLES;
				hold_off_req = 1'b0;
			end else begin
				stall = gaps_on ? $urandom_range(0, 5) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	// offer one transaction, leave tvalid high when the next follows at once
	task automatic send_item(logic kind, logic [IDX_W-1:0] row,
		logic [IDX_W-1:0] col, logic [COEF_W-1:0] coef);
		int gap;
		s_tuser  <= kind;
		s_tdata  <= {4'b0, coef, col, row};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic load_coef(int row, int col, logic [COEF_W-1:0] coef);
		loaded[row][col] = 1'b1;
		send_item(KIND_LOAD, IDX_W'(row), IDX_W'(col), coef);
	endtask

	// query transactions carry junk in the coefficient field
	task automatic query_entry(int a, int b);
		send_item(KIND_QUERY, IDX_W'(a), IDX_W'(b), COEF_W'($urandom));
	endtask

	// stop offering and wait until every density result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() > 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// registers change only with the block idle
	task automatic set_config(int closed_n, int open_n, logic [MODE_W-1:0] mode);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_CLOSED_COUNT, 7'(closed_n));
		write_reg(REG_OPEN_COUNT, 7'(open_n));
		write_reg(REG_OPEN_MODE, 7'(mode));
		cur_closed = closed_n;
		cur_open   = open_n;
		cur_mode   = mode;
	endtask

	// columns a query reads under the current setting
	function automatic int cols_needed();
		int need;
		case (cur_mode)
			MODE_SUMMED: need = cur_closed + cur_open;
			MODE_TWO:    need = cur_closed + 2;
			default:     need = cur_closed;
		endcase
		return (need > NCOLS) ? NCOLS : need;
	endfunction

	function automatic bit row_ready(int r, int need);
		for (int k = 0; k < need; k++)
			if (!loaded[r][k])
				return 1'b0;
		return 1'b1;
	endfunction

	// never touch an entry that was not written: fall back on a filled row
	function automatic int pick_row(int need);
		int r;
		repeat (12) begin
			r = $urandom_range(0, NROWS - 1);
			if (row_ready(r, need))
				return r;
		end
		return fill_rows[$urandom_range(0, 7)];
	endfunction

	// extremes and tiny values weighted up against plain random ones
	function automatic logic [COEF_W-1:0] draw_coef();
		case ($urandom_range(0, 7))
			0:       return COEF_MIN;
			1:       return COEF_MAX;
			2:       return COEF_W'($urandom_range(0, 1023));
			3:       return -COEF_W'($urandom_range(0, 1023));
			default: return COEF_W'($urandom);
		endcase
	endfunction

	task automatic random_item();
		int need;
		int a;
		int b;
		if ($urandom_range(0, 99) < 35) begin
			a = ($urandom_range(0, 1) == 0) ? fill_rows[$urandom_range(0, 7)]
				: $urandom_range(0, NROWS - 1);
			load_coef(a, $urandom_range(0, NCOLS - 1), draw_coef());
		end else begin
			need = cols_needed();
			a    = pick_row(need);
			b    = ($urandom_range(0, 3) == 0) ? a : pick_row(need);
			query_entry(a, b);
		end
	endtask

	task automatic run_phase(int closed_n, int open_n, logic [MODE_W-1:0] mode,
		bit with_gaps, bit long_hold, bit pause_mid);
		set_config(closed_n, open_n, mode);
		gaps_on = with_gaps;
		if (long_hold)
			hold_off_req = 1'b1;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (pause_mid && n == PHASE_ITEMS / 2)
				drain_results();
			random_item();
		end
	endtask

	initial begin : stimulus
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = KIND_LOAD;
		cfg_we       = 1'b0;
		cfg_index    = REG_CLOSED_COUNT;
		cfg_data     = '0;
		gaps_on      = 1'b1;
		hold_off_req = 1'b0;
		quiet_cycles = 0;
		cur_closed   = 0;
		cur_open     = 0;
		cur_mode     = MODE_CLOSED;
		// fixed rows cover every index bit both ways, the rest are random
		fill_rows = '{0, NROWS - 1, 21, 42, 0, 0, 0, 0};
		for (int n = 4; n < 8; n++)
			fill_rows[n] = $urandom_range(1, NROWS - 2);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// write to the unused register index must change nothing
		write_reg(REG_SPARE, 7'h7f);
		set_config(1, 1, MODE_SUMMED);

		// directed: rounding ties both signs, extremes, swapped query order
		load_coef(1, 0, 24'd1024);
		load_coef(1, 1, -24'd1024);
		load_coef(2, 0, 24'd512);
		load_coef(2, 1, 24'd512);
		load_coef(3, 0, -24'd1024);
		load_coef(3, 1, 24'd1024);
		load_coef(0, 0, COEF_MIN);
		load_coef(0, 1, COEF_MIN);
		load_coef(NROWS - 1, 0, COEF_MAX);
		load_coef(NROWS - 1, 1, COEF_MAX);
		query_entry(1, 2);
		query_entry(2, 1);
		query_entry(3, 2);
		query_entry(1, 1);
		query_entry(0, 0);
		query_entry(0, NROWS - 1);
		query_entry(NROWS - 1, 0);
		query_entry(NROWS - 1, NROWS - 1);

		// whole rows so that wide column ranges stay on written entries;
		// row 0 all minimum and the top row all maximum drive saturation
		for (int n = 0; n < 8; n++)
			for (int c = 0; c < NCOLS; c++)
				load_coef(fill_rows[n], c,
					(n == 0) ? COEF_MIN : (n == 1) ? COEF_MAX : draw_coef());

		// closed sum over every column, saturating
		run_phase(NCOLS, 0, MODE_CLOSED, 1'b1, 1'b0, 1'b0);
		run_phase(0, NCOLS, MODE_SUMMED, 1'b1, 1'b0, 1'b0);
		// open range past the last column, receiver holds off to fill the block
		run_phase(60, NCOLS, MODE_SUMMED, 1'b1, 1'b1, 1'b0);
		// second single open column falls past the store
		run_phase(NCOLS - 1, 5, MODE_TWO, 1'b1, 1'b0, 1'b0);
		// both single open columns past the store, sender pauses midway
		run_phase(NCOLS, NCOLS, MODE_TWO, 1'b1, 1'b0, 1'b1);
		// empty ranges, back to back traffic
		run_phase(0, 0, MODE_CLOSED, 1'b0, 1'b0, 1'b0);
		// undefined mode code acts as closed only
		run_phase(10, 20, MODE_SPARE, 1'b1, 1'b0, 1'b0);
		run_phase(0, 0, MODE_TWO, 1'b1, 1'b0, 1'b0);
		run_phase($urandom_range(0, NCOLS), $urandom_range(0, NCOLS),
			MODE_W'($urandom_range(0, 3)), 1'b0, 1'b0, 1'b0);
		run_phase($urandom_range(0, NCOLS), $urandom_range(0, NCOLS),
			MODE_W'($urandom_range(0, 3)), 1'b1, 1'b0, 1'b0);

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
